// File: rtl/s256sh_pkg.sv
package s256sh_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned HashWords  = 8;
   localparam int unsigned SchedWords = 16;
   localparam int unsigned Rounds     = 64;

   localparam logic ACTION_ABSORB = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam logic [WordWidth-1:0] ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [WordWidth-1:0] INIT_H [HashWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_UPDATE,
      ST_OUT
   } state_type;

   // What happens after the current compression finishes.
   typedef enum logic [1:0] {
      MODE_ABSORB,
      MODE_FIRST_OF_TWO,
      MODE_FINAL
   } mode_type;

   typedef struct packed {
      logic       absorb;
      logic       pad_first;
      logic       pad_second;
      logic       load_work;
      logic       round;
      logic       update_hash;
      logic       clear;
      logic [5:0] round_idx;
      logic [2:0] word_idx;
   } cmd_type;

   typedef struct packed {
      logic last_byte;
      logic two_blocks;
   } status_type;

endpackage

// File: rtl/s256sh_ctrl.sv
module s256sh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word,
   output s256sh_pkg::cmd_type  cmd,
   input  s256sh_pkg::status_type status
);
   import s256sh_pkg::*;

   state_type  state_ff, state_in;
   mode_type   mode_ff, mode_in;
   logic [5:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_ABSORB;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.round_idx = cnt_ff;
      cmd.word_idx  = cnt_ff[2:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACTION_FINISH) begin
                  cmd.pad_first = 1'b1;
                  mode_in  = status.two_blocks ? MODE_FIRST_OF_TWO : MODE_FINAL;
                  state_in = ST_LOAD;
               end else begin
                  cmd.absorb = 1'b1;
                  if (status.last_byte) begin
                     mode_in  = MODE_ABSORB;
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'(Rounds - 1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_hash = 1'b1;
            cnt_in = '0;
            unique case (mode_ff)
               MODE_ABSORB: begin
                  state_in = ST_IDLE;
               end
               MODE_FIRST_OF_TWO: begin
                  // The schedule window is free again, so the length block goes in now.
                  cmd.pad_second = 1'b1;
                  mode_in  = MODE_FINAL;
                  state_in = ST_LOAD;
               end
               MODE_FINAL: begin
                  state_in = ST_OUT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'(HashWords - 1)) begin
                  cmd.clear = 1'b1;
                  cnt_in    = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_word_index = cnt_ff[2:0];
   assign rsp_last_word  = (cnt_ff[2:0] == 3'(HashWords - 1));

   a_ready_valid_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a digest is being delivered");

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && cnt_ff == 6'(Rounds - 1)) |=> (state_ff == ST_UPDATE))
      else $error("compression did not end after the last round");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (state_ff == ST_IDLE && cnt_ff == '0))
      else $error("controller did not return to idle after the last digest word");

   a_out_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_UPDATE && rsp_word_index == '0))
      else $error("digest delivery started without a final compression");

endmodule

// File: rtl/s256sh_datapath.sv
module s256sh_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_data_byte,
   input  s256sh_pkg::cmd_type    cmd,
   output s256sh_pkg::status_type status,
   output logic [31:0]            rsp_digest_word
);
   import s256sh_pkg::*;

   logic [WordWidth-1:0] hash_ff  [HashWords];
   logic [WordWidth-1:0] hash_in  [HashWords];
   logic [WordWidth-1:0] work_ff  [HashWords];
   logic [WordWidth-1:0] work_in  [HashWords];
   logic [WordWidth-1:0] sched_ff [SchedWords];
   logic [WordWidth-1:0] sched_in [SchedWords];
   logic [5:0]           fill_ff, fill_in;
   logic [60:0]          msg_ff, msg_in;
   logic [63:0]          length_bits;

   function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
      ror = (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      small_sigma0 = ror(v, 7) ^ ror(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      small_sigma1 = ror(v, 17) ^ ror(v, 19) ^ (v >> 10);
   endfunction

   assign length_bits       = {msg_ff, 3'b000};
   assign status.last_byte  = (fill_ff == 6'd63);
   assign status.two_blocks = (fill_ff >= 6'd56);
   assign rsp_digest_word   = hash_ff[cmd.word_idx];

   always_comb begin
      sched_in = sched_ff;
      if (cmd.absorb) begin
         for (int i = 0; i < SchedWords; i++) begin
            for (int j = 0; j < 4; j++) begin
               if (fill_ff == 6'(4 * i + j)) begin
                  sched_in[i][31 - 8 * j -: 8] = req_data_byte;
               end
            end
         end
      end else if (cmd.pad_first) begin
         // Keep the bytes, mark the end, zero the rest; add the length if it fits.
         for (int i = 0; i < SchedWords; i++) begin
            for (int j = 0; j < 4; j++) begin
               if (6'(4 * i + j) == fill_ff) begin
                  sched_in[i][31 - 8 * j -: 8] = PAD_BYTE;
               end else if (6'(4 * i + j) > fill_ff) begin
                  sched_in[i][31 - 8 * j -: 8] = 8'h00;
               end
            end
         end
         if (!status.two_blocks) begin
            sched_in[SchedWords - 2] = length_bits[63:32];
            sched_in[SchedWords - 1] = length_bits[31:0];
         end
      end else if (cmd.pad_second) begin
         for (int i = 0; i < SchedWords - 2; i++) begin
            sched_in[i] = '0;
         end
         sched_in[SchedWords - 2] = length_bits[63:32];
         sched_in[SchedWords - 1] = length_bits[31:0];
      end else if (cmd.round) begin
         // The window holds w[t] .. w[t+15]; slide it and append w[t+16].
         for (int i = 0; i < SchedWords - 1; i++) begin
            sched_in[i] = sched_ff[i + 1];
         end
         sched_in[SchedWords - 1] = sched_ff[0] + small_sigma0(sched_ff[1]) + sched_ff[9]
                                    + small_sigma1(sched_ff[14]);
      end
   end

   always_comb begin
      logic [31:0] big0, big1, ch, maj, t1;
      big1 = ror(work_ff[4], 6) ^ ror(work_ff[4], 11) ^ ror(work_ff[4], 25);
      ch   = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      t1   = work_ff[7] + big1 + ch + ROUND_K[cmd.round_idx] + sched_ff[0];
      big0 = ror(work_ff[0], 2) ^ ror(work_ff[0], 13) ^ ror(work_ff[0], 22);
      maj  = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      work_in = work_ff;
      if (cmd.load_work) begin
         work_in = hash_ff;
      end else if (cmd.round) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + big0 + maj;
      end
   end

   always_comb begin
      hash_in = hash_ff;
      fill_in = fill_ff;
      msg_in  = msg_ff;
      if (cmd.clear) begin
         hash_in = INIT_H;
         fill_in = '0;
         msg_in  = '0;
      end else begin
         if (cmd.update_hash) begin
            for (int i = 0; i < HashWords; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
         end
         if (cmd.absorb) begin
            fill_in = fill_ff + 6'd1;
            msg_in  = msg_ff + 61'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= INIT_H;
         fill_ff <= '0;
         msg_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         fill_ff <= fill_in;
         msg_ff  <= msg_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

endmodule

// File: rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream. Each absorb transaction (req_action = 0) adds req_data_byte
// to the message. The byte that completes a 64-byte block starts a compression: the
// working words are loaded, 64 rounds run at one per cycle, and the result is folded
// into the hash; req_ready stays low until the compression is done. A finish
// transaction (req_action = 1) pads the message, runs one compression, or two when 56
// or more bytes of the last block were buffered, and then delivers eight result
// transactions, digest word 0 first, at up to one per cycle as rsp_ready allows;
// rsp_last_word marks word 7. No new input is taken until the last word is
// delivered, after which the hasher is ready for a new message. The round loop,
// one round per clock, sets the compression time.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import s256sh_pkg::*;

   cmd_type    cmd;
   status_type status;

   s256sh_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word_index (rsp_word_index),
      .rsp_last_word  (rsp_last_word),
      .cmd            (cmd),
      .status         (status)
   );

   s256sh_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_digest_word (rsp_digest_word)
   );

endmodule

// File: bench/sha256_digest_checker.sv
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          failures,
   output int          words_due,
   output int          messages_hashed,
   output int          bytes_absorbed,
   output int          words_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_START [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   logic [31:0]      chain [8];
   logic [7:0]       block_bytes [64];
   logic [5:0]       fill;
   logic [60:0]      msg_len;
   digest_entry_type digest_due [$];
   int               fail_count;
   int               message_count;
   int               byte_total;
   int               checked_count;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   task automatic compress_block();
      logic [31:0] sched [64];
      logic [31:0] wk [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++) begin
         sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                     block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      wk = chain;
      for (int i = 0; i < 64; i++) begin
         t1 = wk[7] + (rotr(wk[4], 6) ^ rotr(wk[4], 11) ^ rotr(wk[4], 25))
            + ((wk[4] & wk[5]) ^ (~wk[4] & wk[6])) + ROUND_CONST[i] + sched[i];
         t2 = (rotr(wk[0], 2) ^ rotr(wk[0], 13) ^ rotr(wk[0], 22))
            + ((wk[0] & wk[1]) ^ (wk[0] & wk[2]) ^ (wk[1] & wk[2]));
         wk[7] = wk[6];
         wk[6] = wk[5];
         wk[5] = wk[4];
         wk[4] = wk[3] + t1;
         wk[3] = wk[2];
         wk[2] = wk[1];
         wk[1] = wk[0];
         wk[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         chain[i] = chain[i] + wk[i];
      end
   endtask

   task automatic absorb_byte(input logic [7:0] data);
      block_bytes[fill] = data;
      msg_len = msg_len + 61'd1;
      byte_total++;
      fill = fill + 6'd1;
      if (fill == 6'd0) begin
         compress_block();
      end
   endtask

   task automatic finish_message();
      logic [63:0]      length_bits;
      int               pos;
      digest_entry_type entry;
      length_bits = {msg_len, 3'b000};
      block_bytes[fill] = 8'h80;
      pos = int'(fill) + 1;
      // No room left for the length field, so the padded block goes out on its own.
      if (pos > 56) begin
         for (int i = pos; i < 64; i++) begin
            block_bytes[i] = 8'h00;
         end
         compress_block();
         pos = 0;
      end
      for (int i = pos; i < 56; i++) begin
         block_bytes[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) begin
         block_bytes[63-i] = length_bits[8*i +: 8];
      end
      compress_block();
      for (int i = 0; i < 8; i++) begin
         entry.word  = chain[i];
         entry.index = 3'(i);
         entry.last  = (i == 7);
         digest_due.push_back(entry);
      end
      chain = HASH_START;
      fill = 6'd0;
      msg_len = 61'd0;
      message_count++;
   endtask

   task automatic check_word();
      digest_entry_type entry;
      if (digest_due.size() == 0) begin
         fail_count++;
         $display("%0t: digest word with no transaction outstanding: expected none, got %h",
                  $time, rsp_digest_word);
      end else begin
         entry = digest_due.pop_front();
         checked_count++;
         if (rsp_digest_word !== entry.word) begin
            fail_count++;
            $display("%0t: digest word %0d: expected %h, got %h",
                     $time, entry.index, entry.word, rsp_digest_word);
         end
         if (rsp_word_index !== entry.index) begin
            fail_count++;
            $display("%0t: word index: expected %0d, got %0d",
                     $time, entry.index, rsp_word_index);
         end
         if (rsp_last_word !== entry.last) begin
            fail_count++;
            $display("%0t: last word flag on word %0d: expected %b, got %b",
                     $time, entry.index, entry.last, rsp_last_word);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chain = HASH_START;
         fill = 6'd0;
         msg_len = 61'd0;
         digest_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_word();
         end
         if (req_valid && req_ready) begin
            if (req_action == s256sh_pkg::ACTION_FINISH) begin
               finish_message();
            end else begin
               absorb_byte(req_data_byte);
            end
         end
      end
      failures        <= fail_count;
      words_due       <= digest_due.size();
      messages_hashed <= message_count;
      bytes_absorbed  <= byte_total;
      words_checked   <= checked_count;
   end

endmodule

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import s256sh_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_action = ACTION_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_ready = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   logic        calm = 1'b0;
   int          stall_left = 0;
   int          items_sent = 0;
   int          failures;
   int          words_due;
   int          messages_hashed;
   int          bytes_absorbed;
   int          words_checked;

   sha256_stream_hasher uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   sha256_digest_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word),
      .failures        (failures),
      .words_due       (words_due),
      .messages_hashed (messages_hashed),
      .bytes_absorbed  (bytes_absorbed),
      .words_checked   (words_checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The receiver stalls in bursts; once the run turns calm and a stall under way ends, it always takes words.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Valid is only dropped when a gap is taken, so back-to-back transactions
   // keep it high without a second assignment in the same step.
   task automatic send_item(input logic act, input logic [7:0] data);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_item(ACTION_ABSORB, 8'($urandom_range(0, 255)));
      end
      send_item(ACTION_FINISH, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty message, the classic three-letter message, then one- and two-byte messages.
      send_item(ACTION_FINISH, 8'hff);
      send_item(ACTION_ABSORB, 8'h61);
      send_item(ACTION_ABSORB, 8'h62);
      send_item(ACTION_ABSORB, 8'h63);
      send_item(ACTION_FINISH, 8'h00);
      send_item(ACTION_ABSORB, 8'h00);
      send_item(ACTION_FINISH, 8'h5a);
      send_item(ACTION_ABSORB, 8'hff);
      send_item(ACTION_ABSORB, 8'h80);
      send_item(ACTION_FINISH, 8'ha5);

      // With 56 bytes buffered the length no longer fits, so a second block follows.
      send_message(56);
      // A full block is compressed on absorb before the finish pads the remainder.
      send_message($urandom_range(64, 66));
      for (int m = 0; m < 4; m++) begin
         if (m == 2) begin
            calm <= 1'b1;
         end
         send_message($urandom_range(0, 12));
      end
      req_valid <= 1'b0;

      @(negedge clock);
      while (words_due != 0) @(negedge clock);
      repeat (150) @(posedge clock);

      $display("Sent %0d transactions: %0d messages, %0d bytes absorbed,",
               items_sent, messages_hashed, bytes_absorbed);
      $display("%0d digest words checked.", words_checked);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

endmodule
